FILE: rtl/dmds_pkg.sv
// Shared types, codes and constants of the dual motor direction sequencer.
// No dependencies; every other file but the two channel interfaces imports this package.
`timescale 1ns / 1ps
`default_nettype none

package dmds_pkg;

  localparam int unsigned CMD_W       = 12;
  localparam int unsigned MAXS_W      = 11;
  localparam int unsigned DLY_W       = 4;
  localparam int unsigned DIVR_W      = 8;
  localparam int unsigned SPD_W       = 8;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 11;

  localparam logic [MAXS_W-1:0] MAX_SPEED_RST     = 11'd1764;
  localparam logic [DLY_W-1:0]  DELAY_TICKS_RST   = 4'd5;
  localparam logic [DIVR_W-1:0] SPEED_DIVISOR_RST = 8'd50;

  // event queue between front and back
  localparam int unsigned EVQ_DEPTH = 2;

  // speed divider: 16-bit dividend, 4 quotient bits per cycle
  localparam int unsigned NUM_W          = 16;
  localparam int unsigned DEN_W          = DIVR_W + 1;
  localparam int unsigned DIV_RADIX_BITS = 4;
  localparam int unsigned DIV_STEPS      = NUM_W / DIV_RADIX_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_SPEED     = 2'd0,
    CFG_DELAY_TICKS   = 2'd1,
    CFG_SPEED_DIVISOR = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    M_NONE    = 4'd0,
    M_DELAY   = 4'd1,
    M_RATE    = 4'd2,
    M_OFF_OFF = 4'd3,
    M_FWD_FWD = 4'd4,
    M_REV_REV = 4'd5,
    M_FWD_REV = 4'd6,
    M_REV_FWD = 4'd7,
    M_FWD_OFF = 4'd8,
    M_OFF_FWD = 4'd9,
    M_REV_OFF = 4'd10,
    M_OFF_REV = 4'd11
  } mode_e;

  typedef enum logic [1:0] {
    DIR_OFF = 2'd0,
    DIR_FWD = 2'd1,
    DIR_REV = 2'd2
  } dir_e;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_MODE = 2'd1,
    EV_RATE = 2'd2
  } ev_kind_e;

  typedef struct packed {
    mode_e                   mode;
    logic signed [CMD_W-1:0] left;
    logic signed [CMD_W-1:0] right;
  } entry_t;

  // one classified tick, front to back
  typedef struct packed {
    ev_kind_e                kind;
    mode_e                   mode;
    logic signed [CMD_W-1:0] held_l;
    logic signed [CMD_W-1:0] held_r;
    logic                    lstop;
    logic                    rstop;
    logic                    rej;
  } ev_t;

  // one tick's writes, back to divider
  typedef struct packed {
    logic                    dw;
    dir_e                    ld;
    dir_e                    rd;
    logic                    lw;
    logic                    rw;
    logic signed [CMD_W-1:0] lv;
    logic signed [CMD_W-1:0] rv;
    logic                    moving;
    logic signed [CMD_W-1:0] act_l;
    logic signed [CMD_W-1:0] act_r;
    logic                    rej;
  } div_req_t;

  function automatic dir_e dir_left(mode_e m);
    dir_e d;
    unique case (m)
      M_FWD_FWD, M_FWD_REV, M_FWD_OFF: d = DIR_FWD;
      M_REV_REV, M_REV_FWD, M_REV_OFF: d = DIR_REV;
      default:                         d = DIR_OFF;
    endcase
    return d;
  endfunction

  function automatic dir_e dir_right(mode_e m);
    dir_e d;
    unique case (m)
      M_FWD_FWD, M_REV_FWD, M_OFF_FWD: d = DIR_FWD;
      M_REV_REV, M_FWD_REV, M_OFF_REV: d = DIR_REV;
      default:                         d = DIR_OFF;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/dmds_cmd_if.sv
// Command channel: valid/ready handshake with one refresh tick as payload.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface dmds_cmd_if;
  logic               valid;
  logic               ready;
  logic signed [11:0] left_command;
  logic signed [11:0] right_command;
  logic               left_stopped;
  logic               right_stopped;

  modport source (output valid, left_command, right_command, left_stopped, right_stopped,
                  input ready);
  modport sink   (input valid, left_command, right_command, left_stopped, right_stopped,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/dmds_res_if.sv
// Result channel: valid/ready handshake carrying the motor writes of one tick.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface dmds_res_if;
  logic               valid;
  logic               ready;
  logic               direction_write;
  logic [1:0]         left_direction;
  logic [1:0]         right_direction;
  logic               left_spd_write;
  logic [7:0]         left_spd;
  logic               right_spd_write;
  logic [7:0]         right_spd;
  logic               moving;
  logic signed [11:0] active_left;
  logic signed [11:0] active_right;
  logic               command_rejected;

  modport source (output valid, direction_write, left_direction, right_direction,
                  left_spd_write, left_spd, right_spd_write, right_spd,
                  moving, active_left, active_right, command_rejected,
                  input ready);
  modport sink   (input valid, direction_write, left_direction, right_direction,
                  left_spd_write, left_spd, right_spd_write, right_spd,
                  moving, active_left, active_right, command_rejected,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/dmds_front.sv
// Front end: range check, held command, mode sort and change classification.
// Depends on dmds_pkg and dmds_cmd_if.
`timescale 1ns / 1ps
`default_nettype none

module dmds_front import dmds_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [MAXS_W-1:0] max_speed_i,
  dmds_cmd_if.sink          cmd_i,
  output logic              ev_valid_o,
  output ev_t               ev_o,
  input  logic              ev_ready_i
);

  logic signed [CMD_W-1:0] held_l_q, held_l_d;
  logic signed [CMD_W-1:0] held_r_q, held_r_d;
  mode_e                   last_mode_q, last_mode_d;

  logic signed [CMD_W:0]   l_x, r_x, ms_pos, ms_neg;
  logic                    rej;
  mode_e                   mode_n;
  logic                    accept;

  function automatic mode_e sort_mode(logic signed [CMD_W-1:0] l,
                                      logic signed [CMD_W-1:0] r);
    mode_e m;
    if (l == 0 || r == 0) begin
      if (l > 0)      m = M_FWD_OFF;
      else if (r > 0) m = M_OFF_FWD;
      else if (l < 0) m = M_REV_OFF;
      else if (r < 0) m = M_OFF_REV;
      else            m = M_OFF_OFF;
    end else if (l > 0 && r > 0) begin
      m = M_FWD_FWD;
    end else if (l < 0 && r < 0) begin
      m = M_REV_REV;
    end else if (l > 0) begin
      m = M_FWD_REV;
    end else begin
      m = M_REV_FWD;
    end
    return m;
  endfunction

  assign cmd_i.ready = ev_ready_i;
  assign ev_valid_o  = cmd_i.valid;
  assign accept      = cmd_i.valid && ev_ready_i;

  always_comb begin
    l_x    = {cmd_i.left_command[CMD_W-1], cmd_i.left_command};
    r_x    = {cmd_i.right_command[CMD_W-1], cmd_i.right_command};
    ms_pos = $signed({2'b00, max_speed_i});
    ms_neg = -ms_pos;
    rej    = (l_x > ms_pos) || (l_x < ms_neg) || (r_x > ms_pos) || (r_x < ms_neg);

    held_l_d = rej ? held_l_q : cmd_i.left_command;
    held_r_d = rej ? held_r_q : cmd_i.right_command;
    mode_n   = sort_mode(held_l_d, held_r_d);
    last_mode_d = mode_n;

    ev_o.mode   = mode_n;
    ev_o.held_l = held_l_d;
    ev_o.held_r = held_r_d;
    ev_o.lstop  = cmd_i.left_stopped;
    ev_o.rstop  = cmd_i.right_stopped;
    ev_o.rej    = rej;
    priority if (mode_n != last_mode_q) begin
      ev_o.kind = EV_MODE;
    end else if (held_l_d != held_l_q || held_r_d != held_r_q) begin
      ev_o.kind = EV_RATE;
    end else begin
      ev_o.kind = EV_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_l_q    <= '0;
      held_r_q    <= '0;
      last_mode_q <= M_OFF_OFF;
    end else if (accept) begin
      held_l_q    <= held_l_d;
      held_r_q    <= held_r_d;
      last_mode_q <= last_mode_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/dmds_evq.sv
// Short FIFO of classified ticks between front end and sequencer.
// Depends on dmds_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dmds_evq import dmds_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  input  ev_t  push_i,
  output logic push_ready_o,
  output logic pop_valid_o,
  output ev_t  pop_o,
  input  logic pop_ready_i
);

  localparam int unsigned PW = (EVQ_DEPTH > 1) ? $clog2(EVQ_DEPTH) : 1;
  localparam int unsigned CW = $clog2(EVQ_DEPTH + 1);

  ev_t           mem_q [EVQ_DEPTH];
  logic [PW-1:0] wptr_q, wptr_d;
  logic [PW-1:0] rptr_q, rptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          push, pop;

  assign push_ready_o = (cnt_q != CW'(EVQ_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_o        = mem_q[rptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    if (push) wptr_d = (wptr_q == PW'(EVQ_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    if (pop)  rptr_d = (rptr_q == PW'(EVQ_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    unique case ({push, pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= push_i;
  end

endmodule

`default_nettype wire

FILE: rtl/dmds_back.sv
// Back end: pending queue, stop/delay sequencing and speed-write selection.
// Depends on dmds_pkg; feeds dmds_div.
`timescale 1ns / 1ps
`default_nettype none

module dmds_back import dmds_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [DLY_W-1:0] delay_ticks_i,
  input  logic             ev_valid_i,
  input  ev_t              ev_i,
  output logic             ev_ready_o,
  output logic             req_valid_o,
  output div_req_t         req_o,
  input  logic             req_ready_i
);

  localparam int unsigned QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  typedef struct packed {
    entry_t [QUEUE_DEPTH-1:0] q;
    entry_t                   cur;
    entry_t                   tgt;
    logic [DLY_W-1:0]         dcnt;
    logic signed [CMD_W-1:0]  sent_l;
    logic signed [CMD_W-1:0]  sent_r;
  } seq_t;

  typedef struct packed {
    seq_t                    st;
    logic                    dw;
    dir_e                    ld;
    dir_e                    rd;
    logic                    lw;
    logic                    rw;
    logic signed [CMD_W-1:0] lv;
    logic signed [CMD_W-1:0] rv;
  } work_t;

  localparam entry_t ENTRY_NONE = '{mode: M_NONE,    left: '0, right: '0};
  localparam entry_t ENTRY_OFF  = '{mode: M_OFF_OFF, left: '0, right: '0};

  seq_t  st_q;
  work_t w;
  logic  pop;

  // speed pair identical to the last one sent is skipped
  function automatic work_t send_speeds(work_t a, logic signed [CMD_W-1:0] l,
                                        logic signed [CMD_W-1:0] r, logic l_on, logic r_on);
    work_t b;
    b = a;
    if (!(l == a.st.sent_l && r == a.st.sent_r)) begin
      if (l_on) begin
        b.lw = 1'b1;
        b.lv = l;
      end
      if (r_on) begin
        b.rw = 1'b1;
        b.rv = r;
      end
      b.st.sent_l = l;
      b.st.sent_r = r;
    end
    return b;
  endfunction

  function automatic work_t apply_mode(work_t a, entry_t e);
    work_t b;
    dir_e  dl, dr;
    b  = a;
    dl = dir_left(e.mode);
    dr = dir_right(e.mode);
    b.dw = 1'b1;
    b.ld = dl;
    b.rd = dr;
    b = send_speeds(b, (dl != DIR_OFF) ? e.left : '0, (dr != DIR_OFF) ? e.right : '0,
                    dl != DIR_OFF, dr != DIR_OFF);
    return b;
  endfunction

  function automatic work_t next_item(work_t a, logic [DLY_W-1:0] dt, logic lstop,
                                      logic rstop);
    work_t  b;
    entry_t it;
    b  = a;
    it = a.st.q[0];
    if (it.mode != M_NONE) begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) b.st.q[i] = a.st.q[i+1];
      b.st.q[QUEUE_DEPTH-1] = ENTRY_NONE;
      b.st.dcnt = '0;
      unique case (it.mode)
        M_DELAY: b.st.dcnt = dt;
        M_RATE: begin
          b.st.tgt.left  = it.left;
          b.st.tgt.right = it.right;
          b = send_speeds(b, it.left, it.right, !lstop, !rstop);
        end
        default: begin
          b = apply_mode(b, it);
          b.st.cur = it;
          b.st.tgt = it;
        end
      endcase
    end
    return b;
  endfunction

  assign pop         = ev_valid_i && req_ready_i;
  assign ev_ready_o  = req_ready_i;
  assign req_valid_o = ev_valid_i;

  always_comb begin
    logic          found, have_empty;
    logic [QW-1:0] empty_idx;
    w           = '0;
    w.st        = st_q;
    w.ld        = DIR_OFF;
    w.rd        = DIR_OFF;
    found       = 1'b0;
    have_empty  = 1'b0;
    empty_idx   = '0;

    unique case (ev_i.kind)
      EV_MODE: begin
        if (w.st.cur.mode == w.st.tgt.mode && w.st.cur.mode == M_OFF_OFF &&
            w.st.dcnt == '0) begin
          for (int i = 1; i < QUEUE_DEPTH; i++) w.st.q[i] = ENTRY_NONE;
          w.st.q[0] = '{mode: ev_i.mode, left: ev_i.held_l, right: ev_i.held_r};
          w = next_item(w, delay_ticks_i, ev_i.lstop, ev_i.rstop);
        end else begin
          if (w.st.tgt.mode != M_OFF_OFF) begin
            w.st.tgt = ENTRY_OFF;
            w.lw = 1'b1;
            w.lv = '0;
            w.rw = 1'b1;
            w.rv = '0;
          end
          for (int i = 2; i < QUEUE_DEPTH; i++) w.st.q[i] = ENTRY_NONE;
          w.st.q[0] = '{mode: M_DELAY, left: '0, right: '0};
          w.st.q[1] = '{mode: ev_i.mode, left: ev_i.held_l, right: ev_i.held_r};
        end
      end
      EV_RATE: begin
        // merge into the rate entry nearest the tail, else take the lowest free slot
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
          if (!found) begin
            if (w.st.q[i].mode == M_RATE) begin
              w.st.q[i].left  = ev_i.held_l;
              w.st.q[i].right = ev_i.held_r;
              found = 1'b1;
            end else if (w.st.q[i].mode == M_NONE) begin
              have_empty = 1'b1;
              empty_idx  = QW'(i);
            end
          end
        end
        if (!found && have_empty)
          w.st.q[empty_idx] = '{mode: M_RATE, left: ev_i.held_l, right: ev_i.held_r};
      end
      default: ;
    endcase

    // queue runner
    if (w.st.dcnt != '0) begin
      w.st.dcnt = w.st.dcnt - 1'b1;
      if (w.st.dcnt == '0) w = next_item(w, delay_ticks_i, ev_i.lstop, ev_i.rstop);
    end else if (w.st.cur.mode != M_OFF_OFF && w.st.tgt.mode == M_OFF_OFF) begin
      if (ev_i.lstop && ev_i.rstop) begin
        w.st.cur = w.st.tgt;
        w = next_item(w, delay_ticks_i, ev_i.lstop, ev_i.rstop);
      end else begin
        w.lw = 1'b1;
        w.lv = '0;
        w.rw = 1'b1;
        w.rv = '0;
      end
    end else begin
      w = next_item(w, delay_ticks_i, ev_i.lstop, ev_i.rstop);
    end
  end

  always_comb begin
    req_o.dw     = w.dw;
    req_o.ld     = w.ld;
    req_o.rd     = w.rd;
    req_o.lw     = w.lw;
    req_o.rw     = w.rw;
    req_o.lv     = w.lv;
    req_o.rv     = w.rv;
    req_o.moving = (w.st.cur.mode != M_OFF_OFF);
    req_o.act_l  = w.st.cur.left;
    req_o.act_r  = w.st.cur.right;
    req_o.rej    = ev_i.rej;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) st_q.q[i] <= ENTRY_NONE;
      st_q.cur    <= ENTRY_OFF;
      st_q.tgt    <= ENTRY_OFF;
      st_q.dcnt   <= '0;
      st_q.sent_l <= '0;
      st_q.sent_r <= '0;
    end else if (pop) begin
      st_q <= w.st;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/dmds_div.sv
// Two-lane radix-16 restoring divider: speed = (2*|v| + d) / (2*d), saturated.
// Results go to an output register so the next division can overlap the wait.
// Depends on dmds_pkg, dmds_res_if.
`timescale 1ns / 1ps
`default_nettype none

module dmds_div import dmds_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [DIVR_W-1:0] divisor_i,
  input  logic              start_i,
  input  div_req_t          req_i,
  output logic              ready_o,
  dmds_res_if.source        res_o
);

  localparam int unsigned CNT_W = $clog2(DIV_STEPS);

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] rem;
    logic [NUM_W-1:0] quo;
  } lane_t;

  logic              busy_q, busy_d;
  logic              fin_q, fin_d;
  logic              out_valid_q, out_valid_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  div_req_t          req_q;
  logic [DEN_W-1:0]  den_q;
  lane_t             lane_l_q, lane_r_q;
  lane_t             lane_l_n, lane_r_n;
  logic [DIVR_W-1:0] d_eff;
  logic              last, out_free, move, start;
  logic [NUM_W-1:0]  quo_l, quo_r;
  div_req_t          out_req_q;
  logic [SPD_W-1:0]  out_ls_q, out_rs_q;

  function automatic lane_t lane_step(lane_t a, logic [DEN_W-1:0] den);
    lane_t            b;
    logic [DEN_W:0]   part;
    b = a;
    for (int k = 0; k < DIV_RADIX_BITS; k++) begin
      part  = {b.rem, b.num[NUM_W-1]};
      b.num = {b.num[NUM_W-2:0], 1'b0};
      if (part >= {1'b0, den}) begin
        b.rem = DEN_W'(part - {1'b0, den});
        b.quo = {b.quo[NUM_W-2:0], 1'b1};
      end else begin
        b.rem = part[DEN_W-1:0];
        b.quo = {b.quo[NUM_W-2:0], 1'b0};
      end
    end
    return b;
  endfunction

  function automatic lane_t lane_load(logic signed [CMD_W-1:0] v, logic [DIVR_W-1:0] d);
    lane_t            b;
    logic [CMD_W-1:0] mag;
    mag   = v[CMD_W-1] ? CMD_W'(-v) : CMD_W'(v);
    b.num = NUM_W'({mag[CMD_W-2:0], 1'b0}) + NUM_W'(d);
    b.rem = '0;
    b.quo = '0;
    return b;
  endfunction

  function automatic logic [SPD_W-1:0] sat_speed(logic [NUM_W-1:0] q);
    return (|q[NUM_W-1:SPD_W]) ? '1 : q[SPD_W-1:0];
  endfunction

  assign d_eff    = (divisor_i == '0) ? DIVR_W'(1) : divisor_i;
  assign lane_l_n = lane_step(lane_l_q, den_q);
  assign lane_r_n = lane_step(lane_r_q, den_q);

  // last step this cycle; a finished quotient may wait in the lanes (fin_q)
  assign last     = busy_q && (cnt_q == CNT_W'(DIV_STEPS - 1));
  assign out_free = !out_valid_q || res_o.ready;
  assign move     = (last || fin_q) && out_free;
  assign ready_o  = (!busy_q && !fin_q) || move;
  assign start    = start_i && ready_o;
  assign quo_l    = fin_q ? lane_l_q.quo : lane_l_n.quo;
  assign quo_r    = fin_q ? lane_r_q.quo : lane_r_n.quo;

  always_comb begin
    busy_d      = busy_q;
    fin_d       = fin_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    if (busy_q) cnt_d = cnt_q + 1'b1;
    if (last) begin
      busy_d = 1'b0;
      fin_d  = !out_free;
    end else if (move) begin
      fin_d = 1'b0;
    end
    if (start) begin
      busy_d = 1'b1;
      fin_d  = 1'b0;
      cnt_d  = '0;
    end
    if (move) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      busy_q      <= busy_d;
      fin_q       <= fin_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      req_q    <= req_i;
      den_q    <= {d_eff, 1'b0};
      lane_l_q <= lane_load(req_i.lv, d_eff);
      lane_r_q <= lane_load(req_i.rv, d_eff);
    end else if (busy_q) begin
      lane_l_q <= lane_l_n;
      lane_r_q <= lane_r_n;
    end
    if (move) begin
      out_req_q <= req_q;
      out_ls_q  <= req_q.lw ? sat_speed(quo_l) : '0;
      out_rs_q  <= req_q.rw ? sat_speed(quo_r) : '0;
    end
  end

  assign res_o.valid            = out_valid_q;
  assign res_o.direction_write  = out_req_q.dw;
  assign res_o.left_direction   = out_req_q.ld;
  assign res_o.right_direction  = out_req_q.rd;
  assign res_o.left_spd_write   = out_req_q.lw;
  assign res_o.left_spd         = out_ls_q;
  assign res_o.right_spd_write  = out_req_q.rw;
  assign res_o.right_spd        = out_rs_q;
  assign res_o.moving           = out_req_q.moving;
  assign res_o.active_left      = out_req_q.act_l;
  assign res_o.active_right     = out_req_q.act_r;
  assign res_o.command_rejected = out_req_q.rej;

endmodule

`default_nettype wire

FILE: rtl/dual_motor_direction_sequencer_core.sv
// Top level of the dual motor direction sequencer: config registers, front end,
// event FIFO, sequencer and speed divider. Depends on dmds_pkg and both channel interfaces.
//
//   channel  | role   | one transaction carries
//   ---------+--------+-----------------------------------------------------------
//   cmd_i    | sink   | one refresh tick: signed L/R command, L/R stopped flags
//   res_o    | source | that tick's direction/speed writes, mode status, reject flag
//   cfg_*    | write  | register index 0 max_speed, 1 delay_ticks, 2 speed_divisor
//
// Flow: the front end takes one tick per cycle while the two-entry FIFO has room. The
//   sequencer retires a tick in the cycle the divider starts; the divider works 4 quotient
//   bits per cycle over a 16-bit dividend and can start the next tick on its last step when
//   the output register is free.
// Reset: asynchronous; config returns to 1764 / 5 / 50, pending queue empties, no sweep.
// Stalls: a finished result waits in the output register; one more can finish and wait
//   in the divider, then the sequencer stalls and the front keeps accepting until the
//   FIFO is full.
`timescale 1ns / 1ps
`default_nettype none

module dual_motor_direction_sequencer_core import dmds_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  dmds_cmd_if.sink              cmd_i,
  dmds_res_if.source            res_o
);

  // configuration registers
  logic [MAXS_W-1:0] max_speed_q;
  logic [DLY_W-1:0]  delay_ticks_q;
  logic [DIVR_W-1:0] speed_divisor_q;

  // front -> FIFO
  logic     fe_valid, fe_ready;
  ev_t      fe_ev;
  // FIFO -> sequencer
  logic     ev_valid, ev_ready;
  ev_t      ev;
  // sequencer -> divider
  logic     req_valid, div_ready;
  div_req_t req;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_speed_q     <= MAX_SPEED_RST;
      delay_ticks_q   <= DELAY_TICKS_RST;
      speed_divisor_q <= SPEED_DIVISOR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MAX_SPEED:     max_speed_q     <= cfg_data_i[MAXS_W-1:0];
        CFG_DELAY_TICKS:   delay_ticks_q   <= cfg_data_i[DLY_W-1:0];
        CFG_SPEED_DIVISOR: speed_divisor_q <= cfg_data_i[DIVR_W-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // range check, hold last good command, sort into mode, flag mode/rate changes
  dmds_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .max_speed_i (max_speed_q),
    .cmd_i       (cmd_i),
    .ev_valid_o  (fe_valid),
    .ev_o        (fe_ev),
    .ev_ready_i  (fe_ready)
  );

  // decouples intake from the multi-cycle back end
  dmds_evq u_evq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fe_valid),
    .push_i       (fe_ev),
    .push_ready_o (fe_ready),
    .pop_valid_o  (ev_valid),
    .pop_o        (ev),
    .pop_ready_i  (ev_ready)
  );

  // stop / delay / apply sequencing over the pending queue
  dmds_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .delay_ticks_i (delay_ticks_q),
    .ev_valid_i    (ev_valid),
    .ev_i          (ev),
    .ev_ready_o    (ev_ready),
    .req_valid_o   (req_valid),
    .req_o         (req),
    .req_ready_i   (div_ready)
  );

  // rounded magnitude / divisor, then output register
  dmds_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .divisor_i (speed_divisor_q),
    .start_i   (req_valid),
    .req_i     (req),
    .ready_o   (div_ready),
    .res_o     (res_o)
  );

  // a started division keeps the divider busy on the next cycle
  a_div_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid && div_ready) |=> !div_ready)
    else $error("divider accepted back-to-back starts");

  // directions are only reported when written
  a_dir_only_on_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.direction_write) |->
      (res_o.left_direction == DIR_OFF && res_o.right_direction == DIR_OFF))
    else $error("direction reported without direction write");

  // speeds are only reported when written
  a_speed_only_on_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> ((res_o.left_spd_write || res_o.left_spd == '0) &&
                     (res_o.right_spd_write || res_o.right_spd == '0)))
    else $error("speed reported without speed write");

  // an applied moving mode always carries a non-zero command
  a_moving_matches_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.moving == (res_o.active_left != '0 || res_o.active_right != '0)))
    else $error("moving flag disagrees with active commands");

endmodule

`default_nettype wire

FILE: tb/sv/dual_motor_direction_sequencer_core_tb.sv
// Self-checking testbench for dual_motor_direction_sequencer_core: tick stimulus,
// a cycle-free predictor of the sequencer and an in-order checker of the motor writes.
// Depends on dmds_pkg, dmds_cmd_if, dmds_res_if and the RTL top level.
`timescale 1ns / 1ps

module dual_motor_direction_sequencer_core_tb;
  import dmds_pkg::*;

  localparam int unsigned QDEPTH         = 4;
  localparam int unsigned WATCHDOG_LIMIT = 2000;  // cycles without any transaction
  localparam int unsigned SETTLE_CYCLES  = 8;     // idle wait once every expected result is in

  // one entry of the sequencer's pending plan
  typedef struct {
    mode_e mode;
    int    left;
    int    right;
  } slot_t;

  // everything one result transaction carries
  typedef struct {
    logic               dw;
    logic [1:0]         ld;
    logic [1:0]         rd;
    logic               lw;
    logic [7:0]         ls;
    logic               rw;
    logic [7:0]         rs;
    logic               moving;
    logic signed [11:0] act_l;
    logic signed [11:0] act_r;
    logic               rej;
  } motor_writes_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  dmds_cmd_if cmd_if ();
  dmds_res_if res_if ();

  dual_motor_direction_sequencer_core #(
    .QUEUE_DEPTH(QDEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .cmd_i      (cmd_if),
    .res_o      (res_if)
  );

  // 8 ns period
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: register mirror and sequencer state
  // ---------------------------------------------------------------------------
  int    lim_speed;      // max_speed
  int    settle_ticks;   // delay_ticks
  int    divisor_r;      // speed_divisor
  slot_t plan_q [QDEPTH];
  slot_t cur_slot;
  slot_t tgt_slot;
  int    wait_cnt;
  mode_e prev_mode;
  int    prev_l, prev_r;
  int    hold_l, hold_r;
  int    sent_l, sent_r;
  logic  in_lstop, in_rstop;
  motor_writes_t tick_w;       // writes collected during the tick being predicted

  motor_writes_t motor_writes_q [$];  // expected results, oldest first

  int send_idle_pct;
  int recv_idle_pct;
  int ticks_sent;
  int mismatches;
  int quiet_cycles;

  function automatic void reset_model();
    int i;
    lim_speed    = int'(MAX_SPEED_RST);
    settle_ticks = int'(DELAY_TICKS_RST);
    divisor_r    = int'(SPEED_DIVISOR_RST);
    for (i = 0; i < QDEPTH; i++) plan_q[i] = '{M_NONE, 0, 0};
    cur_slot  = '{M_OFF_OFF, 0, 0};
    tgt_slot  = '{M_OFF_OFF, 0, 0};
    wait_cnt  = 0;
    prev_mode = M_OFF_OFF;
    prev_l = 0; prev_r = 0;
    hold_l = 0; hold_r = 0;
    sent_l = 0; sent_r = 0;
  endfunction

  // magnitude / divisor, rounded half up, saturated; divisor 0 behaves as 1
  function automatic logic [7:0] scaled_speed(int v);
    int mag, d, s;
    mag = (v < 0) ? -v : v;
    d   = (divisor_r == 0) ? 1 : divisor_r;
    s   = (2 * mag + d) / (2 * d);
    if (s > 255) s = 255;
    return 8'(s);
  endfunction

  function automatic void wheel_dirs(input mode_e m, output dir_e l, output dir_e r);
    l = DIR_OFF;
    r = DIR_OFF;
    case (m)
      M_FWD_FWD: begin l = DIR_FWD; r = DIR_FWD; end
      M_REV_REV: begin l = DIR_REV; r = DIR_REV; end
      M_FWD_REV: begin l = DIR_FWD; r = DIR_REV; end
      M_REV_FWD: begin l = DIR_REV; r = DIR_FWD; end
      M_FWD_OFF: l = DIR_FWD;
      M_OFF_FWD: r = DIR_FWD;
      M_REV_OFF: l = DIR_REV;
      M_OFF_REV: r = DIR_REV;
      default: ;
    endcase
  endfunction

  function automatic mode_e classify(int l, int r);
    if (l == 0 || r == 0) begin
      if (l > 0) return M_FWD_OFF;
      if (r > 0) return M_OFF_FWD;
      if (l < 0) return M_REV_OFF;
      if (r < 0) return M_OFF_REV;
      return M_OFF_OFF;
    end
    if (l > 0 && r > 0) return M_FWD_FWD;
    if (l < 0 && r < 0) return M_REV_REV;
    if (l > 0) return M_FWD_REV;
    return M_REV_FWD;
  endfunction

  function automatic void force_zero_speeds();
    tick_w.lw = 1'b1; tick_w.ls = '0;
    tick_w.rw = 1'b1; tick_w.rs = '0;
  endfunction

  // a pair equal to the last one sent is skipped; sent pair tracks even unwritten halves
  function automatic void issue_speeds(int l, int r, logic l_on, logic r_on);
    if (l == sent_l && r == sent_r) return;
    if (l_on) begin
      tick_w.lw = 1'b1;
      tick_w.ls = scaled_speed(l);
    end
    if (r_on) begin
      tick_w.rw = 1'b1;
      tick_w.rs = scaled_speed(r);
    end
    sent_l = l;
    sent_r = r;
  endfunction

  function automatic void engage_mode(slot_t e);
    dir_e ld, rd;
    wheel_dirs(e.mode, ld, rd);
    tick_w.dw = 1'b1;
    tick_w.ld = ld;
    tick_w.rd = rd;
    issue_speeds((ld != DIR_OFF) ? e.left : 0, (rd != DIR_OFF) ? e.right : 0,
                 ld != DIR_OFF, rd != DIR_OFF);
  endfunction

  function automatic void pop_plan();
    slot_t head;
    int i;
    if (plan_q[0].mode == M_NONE) return;
    head = plan_q[0];
    for (i = 0; i + 1 < QDEPTH; i++) plan_q[i] = plan_q[i + 1];
    plan_q[QDEPTH - 1] = '{M_NONE, 0, 0};
    wait_cnt = 0;
    case (head.mode)
      M_DELAY: wait_cnt = settle_ticks;
      M_RATE: begin
        tgt_slot.left  = head.left;
        tgt_slot.right = head.right;
        issue_speeds(head.left, head.right, !in_lstop, !in_rstop);
      end
      default: begin
        engage_mode(head);
        cur_slot = head;
        tgt_slot = head;
      end
    endcase
  endfunction

  function automatic void queue_mode_change(mode_e m);
    int i;
    if (cur_slot.mode == tgt_slot.mode && cur_slot.mode == M_OFF_OFF && wait_cnt == 0) begin
      // at rest: the new mode goes out right away
      plan_q[0] = '{m, hold_l, hold_r};
      for (i = 1; i < QDEPTH; i++) plan_q[i] = '{M_NONE, 0, 0};
      pop_plan();
    end else begin
      if (tgt_slot.mode != M_OFF_OFF) begin
        tgt_slot = '{M_OFF_OFF, 0, 0};
        force_zero_speeds();
      end
      plan_q[0] = '{M_DELAY, 0, 0};
      plan_q[1] = '{m, hold_l, hold_r};
      for (i = 2; i < QDEPTH; i++) plan_q[i] = '{M_NONE, 0, 0};
    end
  endfunction

  // one merged rate entry; dropped when it finds neither a rate entry nor a free slot
  function automatic void merge_rate_change();
    int idx, empty;
    empty = -1;
    for (idx = QDEPTH - 1; idx >= 0; idx--) begin
      if (plan_q[idx].mode == M_RATE) begin
        plan_q[idx].left  = hold_l;
        plan_q[idx].right = hold_r;
        return;
      end
      if (plan_q[idx].mode == M_NONE) empty = idx;
    end
    if (empty >= 0) plan_q[empty] = '{M_RATE, hold_l, hold_r};
  endfunction

  function automatic void advance_plan();
    if (wait_cnt > 0) begin
      wait_cnt--;
      if (wait_cnt == 0) pop_plan();
    end else if (cur_slot.mode != M_OFF_OFF && tgt_slot.mode == M_OFF_OFF) begin
      if (in_lstop && in_rstop) begin
        cur_slot = tgt_slot;
        pop_plan();
      end else begin
        force_zero_speeds();
      end
    end else begin
      pop_plan();
    end
  endfunction

  function automatic motor_writes_t predict_tick(logic signed [11:0] lc, logic signed [11:0] rc,
                                                 logic lstop, logic rstop);
    int    l, r;
    logic  rej;
    mode_e m;
    l   = int'(lc);
    r   = int'(rc);
    rej = (l > lim_speed) || (l < -lim_speed) || (r > lim_speed) || (r < -lim_speed);
    in_lstop = lstop;
    in_rstop = rstop;
    tick_w   = '{default: '0};
    if (!rej) begin
      hold_l = l;
      hold_r = r;
    end
    m = classify(hold_l, hold_r);
    if (m != prev_mode) begin
      prev_mode = m;
      prev_l = hold_l; prev_r = hold_r;
      queue_mode_change(m);
    end else if (prev_l != hold_l || prev_r != hold_r) begin
      prev_l = hold_l; prev_r = hold_r;
      merge_rate_change();
    end
    advance_plan();
    tick_w.moving = (cur_slot.mode != M_OFF_OFF);
    tick_w.act_l  = 12'(cur_slot.left);
    tick_w.act_r  = 12'(cur_slot.right);
    tick_w.rej    = rej;
    return tick_w;
  endfunction

  function automatic string show_writes(motor_writes_t w);
    return $sformatf({"dir_wr=%0b dir=%0d/%0d spd_wr=%0b/%0b spd=%0d/%0d ",
                      "moving=%0b act=%0d/%0d rej=%0b"},
                     w.dw, w.ld, w.rd, w.lw, w.rw, w.ls, w.rs, w.moving, w.act_l, w.act_r,
                     w.rej);
  endfunction

  // ---------------------------------------------------------------------------
  // Driving side; every task starts and ends just after a falling edge
  // ---------------------------------------------------------------------------
  task automatic send_tick(logic signed [11:0] lc, logic signed [11:0] rc,
                           logic lstop, logic rstop);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_if.valid = 1'b0;
      @(negedge clk_i);
    end
    cmd_if.valid         = 1'b1;
    cmd_if.left_command  = lc;
    cmd_if.right_command = rc;
    cmd_if.left_stopped  = lstop;
    cmd_if.right_stopped = rstop;
    do @(posedge clk_i); while (!cmd_if.ready);
    // transaction taken at this edge
    motor_writes_q.push_back(predict_tick(lc, rc, lstop, rstop));
    ticks_sent++;
    @(negedge clk_i);
    cmd_if.valid = 1'b0;
  endtask

  // hold off until every expected result is in, then let the pipeline settle
  task automatic drain_results();
    while (motor_writes_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, int val);
    drain_results();
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = CFG_DATA_W'(val);
    @(negedge clk_i);
    cfg_we = 1'b0;
    case (idx)
      CFG_MAX_SPEED:     lim_speed    = val & 'h7FF;
      CFG_DELAY_TICKS:   settle_ticks = val & 'hF;
      CFG_SPEED_DIVISOR: divisor_r    = val & 'hFF;
      default: ;
    endcase
  endtask

  function automatic int rand_sign();
    return int'($urandom_range(2)) - 1;
  endfunction

  // an in-range command of the given sign, biased to the extremes
  function automatic int pick_cmd(int sgn);
    int mag;
    if (sgn == 0) return 0;
    case ($urandom_range(3))
      0: mag = lim_speed;
      1: mag = 1;
      default: mag = (lim_speed > 1) ? int'($urandom_range(lim_speed, 1)) : 1;
    endcase
    if (mag == 0) mag = 1;
    return sgn * mag;
  endfunction

  // a command beyond max_speed; -2048 is out of range at any setting
  function automatic int over_cmd();
    if (lim_speed >= 2047 || $urandom_range(3) == 0) return -2048;
    return rand_sign() == 0 ? -2048 :
           (($urandom_range(1) == 0) ? 1 : -1) * int'($urandom_range(2047, lim_speed + 1));
  endfunction

  // one motion request held for a while: stop reports arrive at random, with
  // speed trims inside the same mode and the odd out-of-range command
  task automatic run_motion();
    int   sl, sr, l, r, n, k;
    logic lst, rstp;
    sl = rand_sign();
    sr = rand_sign();
    l  = pick_cmd(sl);
    r  = pick_cmd(sr);
    n  = int'($urandom_range(settle_ticks + 6, 2));
    for (k = 0; k < n; k++) begin
      lst  = $urandom_range(99) < 70;
      rstp = $urandom_range(99) < 70;
      case ($urandom_range(9))
        0: send_tick(12'(over_cmd()), 12'(r), lst, rstp);
        1: send_tick(12'(l), 12'(over_cmd()), lst, rstp);
        2, 3: begin
          l = pick_cmd(sl);
          r = pick_cmd(sr);
          send_tick(12'(l), 12'(r), lst, rstp);
        end
        default: send_tick(12'(l), 12'(r), lst, rstp);
      endcase
    end
  endtask

  task automatic run_random(int n_items, int noise_pct);
    int goal;
    goal = ticks_sent + n_items;
    while (ticks_sent < goal) begin
      if ($urandom_range(99) < noise_pct)
        send_tick(12'($urandom), 12'($urandom), 1'($urandom), 1'($urandom));
      else
        run_motion();
      if ($urandom_range(99) < 4) drain_results();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // reset settings: range check, first apply, rate changes, stop and the 5-tick delay
  task automatic test_reset_defaults();
    send_tick(12'sd2047, 12'sd0, 1'b1, 1'b1);        // above max_speed: rejected
    send_tick(-12'sd2048, -12'sd2048, 1'b0, 1'b0);   // most negative code: rejected
    send_tick(12'sd1764, -12'sd1764, 1'b1, 1'b1);    // from rest: applied at once
    send_tick(12'sd1764, -12'sd1, 1'b0, 1'b0);       // rate change
    send_tick(12'sd25, -12'sd1, 1'b0, 1'b1);         // half rounds up; right stopped
    send_tick(12'sd1764, 12'sd1764, 1'b0, 1'b0);     // mode change, motors still turning
    send_tick(-12'sd1764, -12'sd1764, 1'b1, 1'b1);   // retarget while stopping; delay starts
    send_tick(-12'sd1764, -12'sd1764, 1'b1, 1'b1);
    send_tick(-12'sd1000, -12'sd1764, 1'b1, 1'b1);   // rate change queued behind the mode
    send_tick(-12'sd1000, -12'sd1000, 1'b0, 1'b0);   // merges into the same rate entry
    send_tick(-12'sd1000, -12'sd1000, 1'b0, 1'b0);
    send_tick(-12'sd1000, -12'sd1000, 1'b0, 1'b0);   // delay over: mode applied
    send_tick(-12'sd1000, -12'sd1000, 1'b0, 1'b0);   // then the merged rate
  endtask

  // all nine modes with a one-tick delay, then a speed pair that must not be resent
  task automatic test_every_mode();
    int sl [9] = '{1, 0, -1, 0, 1, -1, -1, 0, 1};
    int sr [9] = '{0, 1, 0, -1, -1, 1, -1, 0, 1};
    int k, mag;
    write_reg(CFG_DELAY_TICKS, 1);
    for (k = 0; k < 9; k++) begin
      mag = 100 + 200 * k;
      send_tick(12'(sl[k] * mag), 12'(sr[k] * mag), 1'b1, 1'b1);
      send_tick(12'(sl[k] * mag), 12'(sr[k] * mag), 1'b1, 1'b1);
    end
    // away and straight back before the new mode lands: same speeds, no speed write
    send_tick(-12'sd1700, -12'sd1700, 1'b0, 1'b0);
    send_tick(12'sd1700, 12'sd1700, 1'b1, 1'b1);
    send_tick(12'sd1700, 12'sd1700, 1'b1, 1'b1);
  endtask

  task automatic test_high_limits();
    write_reg(CFG_MAX_SPEED, 2047);
    write_reg(CFG_DELAY_TICKS, 0);
    write_reg(CFG_SPEED_DIVISOR, 1);
    run_random(100, 10);
  endtask

  task automatic test_low_limits();
    write_reg(CFG_MAX_SPEED, 1);
    write_reg(CFG_DELAY_TICKS, 15);
    write_reg(CFG_SPEED_DIVISOR, 255);
    run_random(50, 10);
  endtask

  // divisor 0 acts as 1, delay 0 skips the wait, max_speed 0 takes only zero commands
  task automatic test_zero_registers();
    write_reg(CFG_SPEED_DIVISOR, 0);
    write_reg(CFG_DELAY_TICKS, 0);
    write_reg(CFG_MAX_SPEED, 1000);
    run_random(30, 10);
    write_reg(CFG_MAX_SPEED, 0);
    run_random(20, 20);
  endtask

  task automatic test_random_settings(int rounds);
    int k;
    for (k = 0; k < rounds; k++) begin
      write_reg(CFG_MAX_SPEED, int'($urandom_range(2047, 1)));
      write_reg(CFG_DELAY_TICKS, int'($urandom_range(15)));
      write_reg(CFG_SPEED_DIVISOR, int'($urandom_range(255)));
      run_random(60, 15);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // receiver back-pressure, changed on the falling edge only
  always @(negedge clk_i) begin
    res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // in-order check of every result transaction
  always @(posedge clk_i) begin : check_results
    motor_writes_t want, got;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got = '{res_if.direction_write, res_if.left_direction, res_if.right_direction,
              res_if.left_spd_write, res_if.left_spd, res_if.right_spd_write,
              res_if.right_spd, res_if.moving, res_if.active_left, res_if.active_right,
              res_if.command_rejected};
      if (motor_writes_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing pending: %s", $time, show_writes(got));
      end else begin
        want = motor_writes_q.pop_front();
        if (want.dw !== got.dw || want.ld !== got.ld || want.rd !== got.rd ||
            want.lw !== got.lw || want.ls !== got.ls || want.rw !== got.rw ||
            want.rs !== got.rs || want.moving !== got.moving ||
            want.act_l !== got.act_l || want.act_r !== got.act_r || want.rej !== got.rej) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result mismatch", $time);
            $display("  expected %s", show_writes(want));
            $display("  actual   %s", show_writes(got));
          end
        end
      end
    end
  end

  // watchdog: ends a run in which no transaction moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", motor_writes_q.size());
        $display("dual_motor_direction_sequencer_core test failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Run sequence
  // ---------------------------------------------------------------------------
  initial begin
    cmd_if.valid         = 1'b0;
    cmd_if.left_command  = '0;
    cmd_if.right_command = '0;
    cmd_if.left_stopped  = 1'b0;
    cmd_if.right_stopped = 1'b0;
    res_if.ready         = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = CFG_MAX_SPEED;
    cfg_data             = '0;
    rst_ni               = 1'b0;
    ticks_sent           = 0;
    mismatches           = 0;
    quiet_cycles         = 0;
    reset_model();

    // sender idles 30%, receiver 50%
    send_idle_pct = 30;
    recv_idle_pct = 50;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_defaults();
    test_every_mode();
    test_high_limits();

    // roles swapped: sender idles 50%, receiver 30%
    send_idle_pct = 50;
    recv_idle_pct = 30;
    test_low_limits();
    test_zero_registers();
    test_random_settings(2);

    // full rate on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_settings(3);

    drain_results();
    repeat (2 * SETTLE_CYCLES) @(negedge clk_i);
    if (mismatches == 0 && motor_writes_q.size() == 0) begin
      $display("dual_motor_direction_sequencer_core test passed");
    end else begin
      $display("dual_motor_direction_sequencer_core test failed");
    end
    $finish;
  end

endmodule
